/* rtl/core/dmec_pkg.sv */
// dmec_pkg: shared codes, result type and mode rule tables for the mode event controller
`default_nettype none
package dmec_pkg;

   localparam int MODE_W = 4;
   localparam int EV_W = 4;
   localparam int OP_W = 2;
   localparam int KIND_W = 2;
   localparam int LED_W = 4;
   localparam int BUZZ_W = 3;
   localparam int TICK_W = 32;
   localparam int HOLD_W = 16;

   localparam int QUEUE_DEPTH_DEF = 8;
   localparam int RUN_LIMIT = 7;
   localparam int CNT_W = $clog2(RUN_LIMIT + 1);

   localparam logic [HOLD_W-1:0] HOLD_RESET = 16'd5000;

   // item codes
   localparam logic [OP_W-1:0] OP_POST = 2'd0;
   localparam logic [OP_W-1:0] OP_RUN = 2'd1;
   localparam logic [OP_W-1:0] OP_FORCE = 2'd2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_POST = 2'd0;
   localparam logic [KIND_W-1:0] KIND_APPLIED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;
   localparam logic [KIND_W-1:0] KIND_FORCE = 2'd3;

   // modes
   localparam logic [MODE_W-1:0] MODE_BOOT = 4'd0;
   localparam logic [MODE_W-1:0] MODE_UNREG = 4'd1;
   localparam logic [MODE_W-1:0] MODE_PAIRING = 4'd2;
   localparam logic [MODE_W-1:0] MODE_CALIB = 4'd3;
   localparam logic [MODE_W-1:0] MODE_ACTIVE = 4'd4;
   localparam logic [MODE_W-1:0] MODE_LAMP = 4'd5;
   localparam logic [MODE_W-1:0] MODE_CHARGING = 4'd6;
   localparam logic [MODE_W-1:0] MODE_LOW_BATT = 4'd7;
   localparam logic [MODE_W-1:0] MODE_FACTORY = 4'd8;
   localparam logic [MODE_W-1:0] MODE_ERROR = 4'd9;
   localparam logic [MODE_W-1:0] MODE_SOFT_RST = 4'd10;

   // events
   localparam logic [EV_W-1:0] EV_NONE = 4'd0;
   localparam logic [EV_W-1:0] EV_REGISTER = 4'd1;
   localparam logic [EV_W-1:0] EV_CALIB_DONE = 4'd2;
   localparam logic [EV_W-1:0] EV_CALIB_CMD = 4'd3;
   localparam logic [EV_W-1:0] EV_CHG_ON = 4'd4;
   localparam logic [EV_W-1:0] EV_BATT_LOW = 4'd5;
   localparam logic [EV_W-1:0] EV_LAMP_ON = 4'd6;
   localparam logic [EV_W-1:0] EV_SOFT_RESET = 4'd7;
   localparam logic [EV_W-1:0] EV_FACTORY = 4'd8;
   localparam logic [EV_W-1:0] EV_SENSOR_ERR = 4'd9;
   localparam logic [EV_W-1:0] EV_LAMP_OFF = 4'd10;
   localparam logic [EV_W-1:0] EV_CHG_OFF = 4'd11;
   localparam logic [EV_W-1:0] EV_BATT_OK = 4'd12;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic              accepted;
      logic [MODE_W-1:0] mode;
      logic              entered;
      logic [LED_W-1:0]  led_pattern;
      logic [BUZZ_W-1:0] buzzer_sound;
      logic              reset_request;
      logic              lamp_flag;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic              hit;
      logic [MODE_W-1:0] target;
      logic              lamp;
   } rule_type;

   function automatic logic [LED_W-1:0] led_of(input logic [MODE_W-1:0] m);
      logic [LED_W-1:0] v;
      case (m)
         MODE_UNREG:    v = 4'd1;
         MODE_PAIRING:  v = 4'd1;
         MODE_CALIB:    v = 4'd2;
         MODE_ACTIVE:   v = 4'd3;
         MODE_LAMP:     v = 4'd4;
         MODE_CHARGING: v = 4'd5;
         MODE_LOW_BATT: v = 4'd6;
         MODE_FACTORY:  v = 4'd7;
         MODE_ERROR:    v = 4'd8;
         default:       v = 4'd0;
      endcase
      return v;
   endfunction

   function automatic logic [BUZZ_W-1:0] buzz_of(input logic [MODE_W-1:0] m);
      logic [BUZZ_W-1:0] v;
      case (m)
         MODE_UNREG:    v = 3'd1;
         MODE_ACTIVE:   v = 3'd2;
         MODE_LOW_BATT: v = 3'd3;
         MODE_FACTORY:  v = 3'd4;
         MODE_ERROR:    v = 3'd5;
         default:       v = 3'd0;
      endcase
      return v;
   endfunction

   // mode transition rules; hold_over is the factory hold time check
   function automatic rule_type apply_rule(input logic [MODE_W-1:0] m, input logic lamp,
                                           input logic [EV_W-1:0] ev, input logic hold_over);
      rule_type r;
      r.hit = 1'b0;
      r.target = m;
      r.lamp = lamp;
      case (m)
         MODE_UNREG: begin
            if (ev == EV_REGISTER) begin
               r.hit = 1'b1;
               r.target = MODE_PAIRING;
            end
         end
         MODE_PAIRING: begin
            if (ev == EV_CALIB_DONE) begin
               r.hit = 1'b1;
               r.target = MODE_ACTIVE;
            end else if (ev == EV_CALIB_CMD) begin
               r.hit = 1'b1;
               r.target = MODE_CALIB;
            end
         end
         MODE_CALIB: begin
            if (ev == EV_CALIB_DONE) begin
               r.hit = 1'b1;
               r.target = MODE_ACTIVE;
            end
         end
         MODE_ACTIVE: begin
            r.hit = 1'b1;
            case (ev)
               EV_CHG_ON:     r.target = lamp ? MODE_LAMP : MODE_CHARGING;
               EV_BATT_LOW:   r.target = MODE_LOW_BATT;
               EV_LAMP_ON: begin
                  r.lamp = 1'b1;
                  r.target = MODE_LAMP;
               end
               EV_SOFT_RESET: r.target = MODE_SOFT_RST;
               EV_FACTORY:    r.target = MODE_FACTORY;
               EV_SENSOR_ERR: r.target = MODE_ERROR;
               EV_CALIB_CMD:  r.target = MODE_CALIB;
               default:       r.hit = 1'b0;
            endcase
         end
         MODE_LAMP: begin
            if (ev == EV_LAMP_OFF) begin
               r.hit = 1'b1;
               r.lamp = 1'b0;
               r.target = MODE_CHARGING;
            end else if (ev == EV_CHG_OFF) begin
               r.hit = 1'b1;
               r.lamp = 1'b0;
               r.target = MODE_ACTIVE;
            end
         end
         MODE_CHARGING: begin
            if (ev == EV_CHG_OFF) begin
               r.hit = 1'b1;
               r.target = MODE_ACTIVE;
            end else if (ev == EV_LAMP_ON) begin
               r.hit = 1'b1;
               r.lamp = 1'b1;
               r.target = MODE_LAMP;
            end
         end
         MODE_LOW_BATT: begin
            if (ev == EV_BATT_OK) begin
               r.hit = 1'b1;
               r.target = MODE_ACTIVE;
            end else if (ev == EV_CHG_ON) begin
               r.hit = 1'b1;
               r.target = MODE_CHARGING;
            end
         end
         MODE_FACTORY: begin
            if (hold_over) begin
               r.hit = 1'b1;
               r.target = MODE_ACTIVE;
            end
         end
         MODE_ERROR: begin
            if (ev == EV_SOFT_RESET) begin
               r.hit = 1'b1;
               r.target = MODE_SOFT_RST;
            end
         end
         default: r.hit = 1'b0;
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

/* rtl/core/dmec_queue_ram.sv */
// dmec_queue_ram: event queue storage, one write port and one registered read port
`default_nettype none
module dmec_queue_ram #(
   parameter int DEPTH = dmec_pkg::QUEUE_DEPTH_DEF,
   parameter int AW = $clog2(DEPTH)
) (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [AW-1:0]              wr_addr,
   input  wire logic [dmec_pkg::EV_W-1:0]  wr_data,
   input  wire logic [AW-1:0]              rd_addr,
   output logic      [dmec_pkg::EV_W-1:0]  rd_data
);

   logic [dmec_pkg::EV_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* rtl/core/dmec_ctrl.sv */
// dmec_ctrl: queue pointers, run sequencer and mode state with rule application
`default_nettype none
module dmec_ctrl #(
   parameter int DEPTH = dmec_pkg::QUEUE_DEPTH_DEF,
   parameter int AW = $clog2(DEPTH)
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [dmec_pkg::OP_W-1:0]    req_op,
   input  wire logic [dmec_pkg::EV_W-1:0]    req_event_code,
   input  wire logic [dmec_pkg::MODE_W-1:0]  req_forced_state,
   input  wire logic [dmec_pkg::TICK_W-1:0]  req_now_ticks,
   input  wire logic [dmec_pkg::HOLD_W-1:0]  hold_ticks,
   output logic                              wr_en,
   output logic [AW-1:0]                     wr_addr,
   output logic [dmec_pkg::EV_W-1:0]         wr_data,
   output logic [AW-1:0]                     rd_addr,
   input  wire logic [dmec_pkg::EV_W-1:0]    rd_data,
   output logic                              res_valid,
   output dmec_pkg::rsp_type                 res
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN = 1'b1;
   localparam logic [AW-1:0] PTR_LAST = AW'(DEPTH - 1);

   logic                          state_ff, state_in;
   logic [dmec_pkg::MODE_W-1:0]   mode_ff, mode_in;
   logic [dmec_pkg::TICK_W-1:0]   entry_ff, entry_in;
   logic [dmec_pkg::TICK_W-1:0]   now_ff, now_in;
   logic                          lamp_ff, lamp_in;
   logic [AW-1:0]                 wp_ff, wp_in;
   logic [AW-1:0]                 rp_ff, rp_in;
   logic [dmec_pkg::CNT_W-1:0]    cnt_ff, cnt_in;

   logic [AW-1:0]                 wp_next, rp_next;
   logic [dmec_pkg::TICK_W-1:0]   elapsed;
   logic                          hold_over;
   logic                          accept;
   dmec_pkg::rule_type            rule;

   assign wp_next = (wp_ff == PTR_LAST) ? '0 : wp_ff + 1'b1;
   assign rp_next = (rp_ff == PTR_LAST) ? '0 : rp_ff + 1'b1;
   assign elapsed = now_ff - entry_ff;
   assign hold_over = elapsed > {{(dmec_pkg::TICK_W - dmec_pkg::HOLD_W){1'b0}}, hold_ticks};
   assign rule = dmec_pkg::apply_rule(mode_ff, lamp_ff, rd_data, hold_over);
   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff == ST_RUN);

   // read port always points at the head; the registered read data is used in the cycle after its address is given
   assign rd_addr = rp_ff;
   assign wr_addr = wp_ff;
   assign wr_data = req_event_code;

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      entry_in = entry_ff;
      now_in = now_ff;
      lamp_in = lamp_ff;
      wp_in = wp_ff;
      rp_in = rp_ff;
      cnt_in = cnt_ff;
      wr_en = 1'b0;
      res_valid = 1'b0;
      res = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_op)
                  dmec_pkg::OP_POST: begin
                     res_valid = 1'b1;
                     res.kind = dmec_pkg::KIND_POST;
                     if (req_event_code != dmec_pkg::EV_NONE && wp_next != rp_ff) begin
                        wr_en = 1'b1;
                        wp_in = wp_next;
                        res.accepted = 1'b1;
                     end
                  end
                  dmec_pkg::OP_RUN: begin
                     now_in = req_now_ticks;
                     if (rp_ff == wp_ff) begin
                        res_valid = 1'b1;
                        res.kind = dmec_pkg::KIND_EMPTY;
                     end else begin
                        rp_in = rp_next;
                        cnt_in = dmec_pkg::CNT_W'(1);
                        state_in = ST_RUN;
                     end
                  end
                  dmec_pkg::OP_FORCE: begin
                     res_valid = 1'b1;
                     res.kind = dmec_pkg::KIND_FORCE;
                     if (req_forced_state <= dmec_pkg::MODE_SOFT_RST) begin
                        mode_in = req_forced_state;
                        entry_in = req_now_ticks;
                     end
                  end
                  default: res_valid = 1'b0;
               endcase
            end
         end
         ST_RUN: begin
            res_valid = 1'b1;
            res.kind = dmec_pkg::KIND_APPLIED;
            lamp_in = rule.lamp;
            if (rule.hit) begin
               mode_in = rule.target;
               entry_in = now_ff;
               res.entered = 1'b1;
               res.led_pattern = dmec_pkg::led_of(rule.target);
               res.buzzer_sound = dmec_pkg::buzz_of(rule.target);
               res.reset_request = (rule.target == dmec_pkg::MODE_SOFT_RST);
            end
            if (cnt_ff != dmec_pkg::CNT_W'(dmec_pkg::RUN_LIMIT) && rp_ff != wp_ff) begin
               rp_in = rp_next;
               cnt_in = cnt_ff + 1'b1;
            end else begin
               res.last = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      res.mode = mode_in;
      res.lamp_flag = lamp_in;
      if (state_ff == ST_IDLE) begin
         res.last = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mode_ff <= dmec_pkg::MODE_BOOT;
         entry_ff <= '0;
         lamp_ff <= 1'b0;
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         entry_ff <= entry_in;
         lamp_ff <= lamp_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
   end

endmodule
`default_nettype wire

/* rtl/core/device_mode_event_controller_top.sv */
// device_mode_event_controller_top: mode event controller with event queue and hold register
// post, force and empty-run results are registered and appear in the cycle after start is taken
// a run of n queued events (n up to 7) gives n results, one per cycle with no gaps; the first
// follows the registered head read from the queue ram and then the registered result
// busy stays high while the run is in progress, with one queue ram read per result
// the next item may start in the cycle that carries the last result; results cannot stall
// reset: mode boot, lamp flag clear, queue empty, hold time 5000; no clearing pass
`default_nettype none
module device_mode_event_controller_top #(
   parameter int QUEUE_DEPTH = dmec_pkg::QUEUE_DEPTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         start,
   output logic                              busy,
   input  wire logic [dmec_pkg::OP_W-1:0]    req_op,
   input  wire logic [dmec_pkg::EV_W-1:0]    req_event_code,
   input  wire logic [dmec_pkg::MODE_W-1:0]  req_forced_state,
   input  wire logic [dmec_pkg::TICK_W-1:0]  req_now_ticks,
   output logic                              rsp_valid,
   output logic [dmec_pkg::KIND_W-1:0]       rsp_kind,
   output logic                              rsp_accepted,
   output logic [dmec_pkg::MODE_W-1:0]       rsp_mode,
   output logic                              rsp_entered,
   output logic [dmec_pkg::LED_W-1:0]        rsp_led_pattern,
   output logic [dmec_pkg::BUZZ_W-1:0]       rsp_buzzer_sound,
   output logic                              rsp_reset_request,
   output logic                              rsp_lamp_flag,
   output logic                              rsp_last,
   input  wire logic                         csr_valid,
   output logic                              csr_ready,
   input  wire logic [dmec_pkg::HOLD_W-1:0]  csr_data
);

   localparam int AW = $clog2(QUEUE_DEPTH);

   logic [dmec_pkg::HOLD_W-1:0]  hold_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   dmec_pkg::rsp_type            rsp_ff, rsp_in;
   logic                         wr_en;
   logic [AW-1:0]                wr_addr, rd_addr;
   logic [dmec_pkg::EV_W-1:0]    wr_data, rd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= dmec_pkg::HOLD_RESET;
      end else if (csr_valid && csr_ready) begin
         hold_ff <= csr_data;
      end
   end

   dmec_queue_ram #(
      .DEPTH(QUEUE_DEPTH),
      .AW(AW)
   ) u_ram (
      .clock(clock),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   dmec_ctrl #(
      .DEPTH(QUEUE_DEPTH),
      .AW(AW)
   ) u_ctrl (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_event_code(req_event_code),
      .req_forced_state(req_forced_state),
      .req_now_ticks(req_now_ticks),
      .hold_ticks(hold_ff),
      .wr_en(wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data),
      .res_valid(rsp_valid_in),
      .res(rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_kind = rsp_ff.kind;
   assign rsp_accepted = rsp_ff.accepted;
   assign rsp_mode = rsp_ff.mode;
   assign rsp_entered = rsp_ff.entered;
   assign rsp_led_pattern = rsp_ff.led_pattern;
   assign rsp_buzzer_sound = rsp_ff.buzzer_sound;
   assign rsp_reset_request = rsp_ff.reset_request;
   assign rsp_lamp_flag = rsp_ff.lamp_flag;
   assign rsp_last = rsp_ff.last;

   // a run streams its results with no gaps
   a_run_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |=> rsp_valid && rsp_kind == dmec_pkg::KIND_APPLIED)
      else $error("run result stream broke before last beat");

   // every post gets exactly one ack on the next cycle
   a_post_ack: assert property (@(posedge clock) disable iff (reset)
      start && !busy && req_op == dmec_pkg::OP_POST
      |=> rsp_valid && rsp_last && rsp_kind == dmec_pkg::KIND_POST)
      else $error("post ack missing");

   // entry actions only on a state entry
   a_entry_actions: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_entered
      |-> rsp_led_pattern == '0 && rsp_buzzer_sound == '0 && !rsp_reset_request)
      else $error("entry action without state entry");

   // the controller frees up exactly when the final beat is shown
   a_last_frees: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("busy still high on last beat");

endmodule
`default_nettype wire
